### rtl/core/swsc_pkg.sv
// ----------------------------------------------------------------------------
// swsc_pkg
// Shared types and constants of the sliding-window sender control.
// ----------------------------------------------------------------------------
`default_nettype none

package swsc_pkg;

	localparam int SEQ_W  = 15;   // sequence number width
	localparam int FLEN_W = 24;   // file length / byte offset width
	localparam int TMO_W  = 16;   // timeout register width
	localparam int TIME_W = 32;   // time stamp width
	localparam int PLEN_W = 11;   // payload length field width
	localparam int PB_W   = 16;   // payload size width (up to 65535)
	localparam int NUM_W  = 25;   // file_length + payload size - 1
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 24;

	localparam logic [SEQ_W-1:0] SEQ_MAX     = '1;
	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd1000;

	localparam logic [1:0] REQ_ISSUE = 2'd0;
	localparam logic [1:0] REQ_ACK   = 2'd1;
	localparam logic [1:0] REQ_SCAN  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS  = 1'd1;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_ISSUE    = 8'b0000_0010,
		ST_DIV      = 8'b0000_0100,
		ST_ACK_RD   = 8'b0000_1000,
		ST_ACK_CHK  = 8'b0001_0000,
		ST_ACK_MARK = 8'b0010_0000,
		ST_SCAN     = 8'b0100_0000,
		ST_RESP     = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

### rtl/core/swsc_ram.sv
// ----------------------------------------------------------------------------
// swsc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module swsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

### rtl/core/swsc_div.sv
// ----------------------------------------------------------------------------
// swsc_div
// Divider by a fixed divisor through multiplication by its reciprocal; the
// quotient is registered and valid in the cycle after go.
// ----------------------------------------------------------------------------
`default_nettype none

module swsc_div #(
	parameter int DIVISOR = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       go,
	input  wire logic [swsc_pkg::NUM_W-1:0] numer,
	output logic                            done,
	output logic      [swsc_pkg::NUM_W-1:0] quot
);

	// quotient = (numer * RCP) >> SHIFT, with RCP = ceil(2^SHIFT / DIVISOR);
	// exact for every numerator below 2^NUM_W
	localparam int LOG_W  = $clog2(DIVISOR);
	localparam int SHIFT  = swsc_pkg::NUM_W + LOG_W;
	localparam int RCP_W  = swsc_pkg::NUM_W + 2;
	localparam int PROD_W = swsc_pkg::NUM_W + RCP_W;
	localparam logic [63:0] RCP_64 =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [RCP_W-1:0] RCP = RCP_64[RCP_W-1:0];

	logic [PROD_W-1:0] prod;

	assign prod = {{RCP_W{1'b0}}, numer} * {{swsc_pkg::NUM_W{1'b0}}, RCP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			quot <= '0;
		end else begin
			done <= go;
			if (go) begin
				quot <= swsc_pkg::NUM_W'(prod >> SHIFT);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/sliding_window_sender_control.sv
// ----------------------------------------------------------------------------
// sliding_window_sender_control
// Sender-side control of a sliding-window transfer: grants sequence numbers,
// takes cumulative acks and looks for timed-out packets.
// ----------------------------------------------------------------------------
// An item is accepted when start is high and busy is low; its result appears
// on the result ports for one cycle with done high, and must be taken then,
// because the block has no way to hold a result. A data issue or a refused
// issue passes through the issue state and an unused request type goes
// straight to the response state; the header issue also waits in the divider
// state for the packet count from the reciprocal-multiply divider; an ack
// reads and checks the flag and, when it is taken, marks the entries from the
// window base to the acked sequence (one window entry marked per cycle); a
// timeout check walks at most the outstanding entries, as the scan reads one
// entry of the stamp and ack-flag memories per cycle. busy drops in the done
// cycle, so the next item can be accepted then. Configuration writes are
// taken only while idle. Window state lives in two RAMs with registered read
// and needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sender_control #(
	parameter int WINDOW_DEPTH  = 8,
	parameter int PAYLOAD_BYTES = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// request channel
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [1:0]                      req_type,
	input  wire logic [swsc_pkg::SEQ_W-1:0]      ack_seq,
	input  wire logic [swsc_pkg::TIME_W-1:0]     cur_time,
	// result channel
	output logic                                 done,
	output logic                                 granted,
	output logic      [swsc_pkg::SEQ_W-1:0]      pkt_seq,
	output logic                                 is_header,
	output logic      [swsc_pkg::FLEN_W-1:0]     byte_offset,
	output logic      [swsc_pkg::PLEN_W-1:0]     payload_len,
	output logic      [swsc_pkg::SEQ_W-1:0]      packet_count,
	output logic                                 resend_found,
	output logic      [swsc_pkg::SEQ_W-1:0]      resend_seq,
	output logic                                 window_full,
	output logic                                 sending_done,
	output logic                                 all_done,
	// configuration
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [swsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [swsc_pkg::CFG_DAT_W-1:0]  cfg_data
);

	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int SEQ_W  = swsc_pkg::SEQ_W;
	localparam int FLEN_W = swsc_pkg::FLEN_W;
	localparam int TIME_W = swsc_pkg::TIME_W;
	localparam int MUL_W  = swsc_pkg::SEQ_W + swsc_pkg::PB_W;

	localparam logic [SEQ_W-1:0]        DEPTH_SEQ  = SEQ_W'(WINDOW_DEPTH);
	localparam logic [SLOT_W:0]         DEPTH_SUM  = (SLOT_W + 1)'(WINDOW_DEPTH);
	localparam logic [SLOT_W-1:0]       SLOT_LAST  = SLOT_W'(WINDOW_DEPTH - 1);
	localparam logic [FLEN_W-1:0]       PB_FL      = FLEN_W'(PAYLOAD_BYTES);
	localparam logic [swsc_pkg::PB_W-1:0] PB_16    = swsc_pkg::PB_W'(PAYLOAD_BYTES);
	localparam logic [swsc_pkg::NUM_W-1:0] PB_M1   = swsc_pkg::NUM_W'(PAYLOAD_BYTES - 1);

	// slot of seq+1, matching seq modulo the depth across the sequence wrap
	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SEQ_W-1:0] seq,
		input logic [SLOT_W-1:0] slot);
		logic [SLOT_W-1:0] r;
		if (seq == swsc_pkg::SEQ_MAX) begin
			r = '0;
		end else if (slot == SLOT_LAST) begin
			r = '0;
		end else begin
			r = slot + 1'b1;
		end
		return r;
	endfunction

	swsc_pkg::state_t state_q;

	// configuration
	logic [FLEN_W-1:0]          flen_q;
	logic [swsc_pkg::TMO_W-1:0] tmo_q;

	// window state
	logic [SEQ_W-1:0]  base_q;
	logic [SLOT_W-1:0] base_slot_q;
	logic [SEQ_W-1:0]  next_seq_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic [FLEN_W-1:0] send_pos_q;
	logic              hdr_sent_q;
	logic              hdr_acked_q;
	logic              last_sent_q;
	logic              last_acked_q;

	// current item
	logic [SEQ_W-1:0]  ack_q;
	logic [TIME_W-1:0] now_q;

	// ack processing
	logic              in_win_q;
	logic              off_ge_q;
	logic [SLOT_W-1:0] mark_left_q;

	// scan cursor and read stage
	logic [SEQ_W-1:0]  cur_seq_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic [SEQ_W-1:0]  cnt_q;
	logic              rd_vld_s1;
	logic [SEQ_W-1:0]  rd_seq_s1;
	logic [SLOT_W-1:0] rd_slot_s1;

	// combinational
	logic [SEQ_W-1:0]  outstanding;
	logic              win_full;
	logic              refuse;
	logic [FLEN_W-1:0] rem;
	logic              is_last;
	logic [SEQ_W-1:0]  ack_d;
	logic              ack_in_win;
	logic [SLOT_W:0]   ack_sum;
	logic [SLOT_W:0]   ack_sum_mod;
	logic [SLOT_W-1:0] ack_slot;
	logic [MUL_W-1:0]  ack_off;
	logic              expired;
	logic              scan_hit;
	logic              do_issue;

	// memories
	logic              ackf_wr_en;
	logic [SLOT_W-1:0] ackf_wr_addr;
	logic              ackf_wr_data;
	logic [SLOT_W-1:0] ackf_rd_addr;
	logic              ackf_rd_data;
	logic              stamp_wr_en;
	logic [SLOT_W-1:0] stamp_wr_addr;
	logic [TIME_W-1:0] stamp_rd_data;

	// divider
	logic                       div_go;
	logic                       div_done;
	logic [swsc_pkg::NUM_W-1:0] div_numer;
	logic [swsc_pkg::NUM_W-1:0] div_quot;

	assign busy      = (state_q != swsc_pkg::ST_IDLE);
	assign cfg_ready = ~busy;

	always_comb begin
		outstanding = next_seq_q - base_q;
		win_full    = (outstanding >= DEPTH_SEQ);
		refuse      = win_full | (hdr_sent_q & ~hdr_acked_q) | last_sent_q;
		rem         = (flen_q > send_pos_q) ? (flen_q - send_pos_q) : '0;
		is_last     = (rem <= PB_FL);

		ack_d       = ack_q - base_q;
		ack_in_win  = (ack_d < outstanding);
		ack_sum     = {1'b0, base_slot_q} + {1'b0, ack_d[SLOT_W-1:0]};
		ack_sum_mod = (ack_sum >= DEPTH_SUM) ? (ack_sum - DEPTH_SUM) : ack_sum;
		// a window that crosses the sequence wrap puts small acks at slot = ack
		ack_slot    = (ack_q < base_q) ? ack_q[SLOT_W-1:0] : ack_sum_mod[SLOT_W-1:0];
		ack_off     = {{swsc_pkg::PB_W{1'b0}}, ack_q} * {{SEQ_W{1'b0}}, PB_16};

		expired  = ~ackf_rd_data & ((now_q - stamp_rd_data) > TIME_W'(tmo_q));
		scan_hit = (state_q == swsc_pkg::ST_SCAN) & rd_vld_s1 & expired;
		do_issue = (state_q == swsc_pkg::ST_ISSUE) & ~refuse;

		ackf_wr_en    = do_issue | (state_q == swsc_pkg::ST_ACK_MARK);
		ackf_wr_addr  = do_issue ? next_slot_q : base_slot_q;
		ackf_wr_data  = (state_q == swsc_pkg::ST_ACK_MARK);
		ackf_rd_addr  = (state_q == swsc_pkg::ST_ACK_RD) ? ack_slot : cur_slot_q;
		stamp_wr_en   = do_issue | scan_hit;
		stamp_wr_addr = do_issue ? next_slot_q : rd_slot_s1;

		div_go    = do_issue & ~hdr_sent_q;
		div_numer = {1'b0, flen_q} + PB_M1;
	end

	swsc_ram #(
		.WIDTH(1),
		.DEPTH(WINDOW_DEPTH)
	) u_ackf_ram (
		.clk     (clk),
		.wr_en   (ackf_wr_en),
		.wr_addr (ackf_wr_addr),
		.wr_data (ackf_wr_data),
		.rd_addr (ackf_rd_addr),
		.rd_data (ackf_rd_data)
	);

	swsc_ram #(
		.WIDTH(TIME_W),
		.DEPTH(WINDOW_DEPTH)
	) u_stamp_ram (
		.clk     (clk),
		.wr_en   (stamp_wr_en),
		.wr_addr (stamp_wr_addr),
		.wr_data (now_q),
		.rd_addr (cur_slot_q),
		.rd_data (stamp_rd_data)
	);

	swsc_div #(
		.DIVISOR(PAYLOAD_BYTES)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.numer  (div_numer),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= swsc_pkg::ST_IDLE;
			flen_q       <= '0;
			tmo_q        <= swsc_pkg::TIMEOUT_RST;
			base_q       <= '0;
			base_slot_q  <= '0;
			next_seq_q   <= '0;
			next_slot_q  <= '0;
			send_pos_q   <= '0;
			hdr_sent_q   <= 1'b0;
			hdr_acked_q  <= 1'b0;
			last_sent_q  <= 1'b0;
			last_acked_q <= 1'b0;
			ack_q        <= '0;
			now_q        <= '0;
			in_win_q     <= 1'b0;
			off_ge_q     <= 1'b0;
			mark_left_q  <= '0;
			cur_seq_q    <= '0;
			cur_slot_q   <= '0;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			rd_seq_s1    <= '0;
			rd_slot_s1   <= '0;
			done         <= 1'b0;
			granted      <= 1'b0;
			pkt_seq      <= '0;
			is_header    <= 1'b0;
			byte_offset  <= '0;
			payload_len  <= '0;
			packet_count <= '0;
			resend_found <= 1'b0;
			resend_seq   <= '0;
			window_full  <= 1'b0;
			sending_done <= 1'b0;
			all_done     <= 1'b0;
		end else begin
			done <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					swsc_pkg::CFG_FILE_LENGTH: flen_q <= cfg_data;
					swsc_pkg::CFG_TIMEOUT_MS: tmo_q <= cfg_data[swsc_pkg::TMO_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				swsc_pkg::ST_IDLE: begin
					if (start) begin
						ack_q        <= ack_seq;
						now_q        <= cur_time;
						cur_seq_q    <= base_q;
						cur_slot_q   <= base_slot_q;
						cnt_q        <= '0;
						rd_vld_s1    <= 1'b0;
						granted      <= 1'b0;
						pkt_seq      <= '0;
						is_header    <= 1'b0;
						byte_offset  <= '0;
						payload_len  <= '0;
						packet_count <= '0;
						resend_found <= 1'b0;
						resend_seq   <= '0;
						case (req_type)
							swsc_pkg::REQ_ISSUE: state_q <= swsc_pkg::ST_ISSUE;
							swsc_pkg::REQ_ACK:   state_q <= swsc_pkg::ST_ACK_RD;
							swsc_pkg::REQ_SCAN:  state_q <= swsc_pkg::ST_SCAN;
							default:             state_q <= swsc_pkg::ST_RESP;
						endcase
					end
				end

				swsc_pkg::ST_ISSUE: begin
					if (refuse) begin
						state_q <= swsc_pkg::ST_RESP;
					end else begin
						granted     <= 1'b1;
						pkt_seq     <= next_seq_q;
						next_seq_q  <= next_seq_q + 1'b1;
						next_slot_q <= slot_inc(next_seq_q, next_slot_q);
						if (!hdr_sent_q) begin
							is_header  <= 1'b1;
							hdr_sent_q <= 1'b1;
							state_q    <= swsc_pkg::ST_DIV;
						end else begin
							byte_offset <= send_pos_q;
							if (is_last) begin
								payload_len <= rem[swsc_pkg::PLEN_W-1:0];
								send_pos_q  <= flen_q;
								last_sent_q <= 1'b1;
							end else begin
								payload_len <= PB_FL[swsc_pkg::PLEN_W-1:0];
								send_pos_q  <= send_pos_q + PB_FL;
							end
							state_q <= swsc_pkg::ST_RESP;
						end
					end
				end

				swsc_pkg::ST_DIV: begin
					if (div_done) begin
						packet_count <= (div_quot[swsc_pkg::NUM_W-1:SEQ_W] != '0)
							? swsc_pkg::SEQ_MAX : div_quot[SEQ_W-1:0];
						state_q <= swsc_pkg::ST_RESP;
					end
				end

				swsc_pkg::ST_ACK_RD: begin
					in_win_q    <= ack_in_win;
					off_ge_q    <= (ack_off >= MUL_W'(flen_q));
					mark_left_q <= ack_d[SLOT_W-1:0];
					state_q     <= swsc_pkg::ST_ACK_CHK;
				end

				swsc_pkg::ST_ACK_CHK: begin
					if (in_win_q && !ackf_rd_data) begin
						if (ack_q == '0) begin
							hdr_acked_q <= 1'b1;
						end else if (off_ge_q) begin
							last_acked_q <= 1'b1;
						end
						state_q <= swsc_pkg::ST_ACK_MARK;
					end else begin
						state_q <= swsc_pkg::ST_RESP;
					end
				end

				swsc_pkg::ST_ACK_MARK: begin
					// flag write happens on the RAM port at base_slot_q
					base_q      <= base_q + 1'b1;
					base_slot_q <= slot_inc(base_q, base_slot_q);
					if (mark_left_q == '0) begin
						state_q <= swsc_pkg::ST_RESP;
					end else begin
						mark_left_q <= mark_left_q - 1'b1;
					end
				end

				swsc_pkg::ST_SCAN: begin
					// reads go out one per cycle; data checked in the cycle after
					if (scan_hit) begin
						resend_found <= 1'b1;
						resend_seq   <= rd_seq_s1;
						rd_vld_s1    <= 1'b0;
						state_q      <= swsc_pkg::ST_RESP;
					end else if (cnt_q != outstanding) begin
						rd_vld_s1  <= 1'b1;
						rd_seq_s1  <= cur_seq_q;
						rd_slot_s1 <= cur_slot_q;
						cur_seq_q  <= cur_seq_q + 1'b1;
						cur_slot_q <= slot_inc(cur_seq_q, cur_slot_q);
						cnt_q      <= cnt_q + 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
						state_q   <= swsc_pkg::ST_RESP;
					end
				end

				swsc_pkg::ST_RESP: begin
					done         <= 1'b1;
					window_full  <= win_full;
					sending_done <= last_sent_q;
					all_done     <= last_acked_q;
					state_q      <= swsc_pkg::ST_IDLE;
				end

				default: begin
					state_q <= swsc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	a_outstanding_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding <= DEPTH_SEQ)
		else $error("outstanding count exceeds window depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_done_after_resp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == swsc_pkg::ST_RESP))
		else $error("result strobe without response state");

	a_no_grant_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swsc_pkg::ST_ISSUE && win_full) |=> !granted)
		else $error("grant issued while window full");

	a_header_granted: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_header) |-> (granted && pkt_seq == '0))
		else $error("header result without grant of sequence zero");

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding-window sender control. Requests go in
// over start/busy and each done strobe is checked against a cycle-free
// predictor of the window state. A directed sequence comes first. Random
// phases follow, and the file length and timeout registers change between
// phases until the transfer has been sent out completely and acked.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEQ_W     = swsc_pkg::SEQ_W;
	localparam int FLEN_W    = swsc_pkg::FLEN_W;
	localparam int TMO_W     = swsc_pkg::TMO_W;
	localparam int TIME_W    = swsc_pkg::TIME_W;
	localparam int PLEN_W    = swsc_pkg::PLEN_W;
	localparam int CFG_IDX_W = swsc_pkg::CFG_IDX_W;
	localparam int CFG_DAT_W = swsc_pkg::CFG_DAT_W;

	localparam logic [SEQ_W-1:0] SEQ_MAX     = swsc_pkg::SEQ_MAX;
	localparam logic [TMO_W-1:0] TIMEOUT_RST = swsc_pkg::TIMEOUT_RST;

	localparam logic [1:0] REQ_ISSUE = swsc_pkg::REQ_ISSUE;
	localparam logic [1:0] REQ_ACK   = swsc_pkg::REQ_ACK;
	localparam logic [1:0] REQ_SCAN  = swsc_pkg::REQ_SCAN;

	localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = swsc_pkg::CFG_FILE_LENGTH;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS  = swsc_pkg::CFG_TIMEOUT_MS;

	localparam int WIN          = 8;
	localparam int PB           = 1024;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef enum {RUN_COUNT, RUN_TO_LAST, RUN_TO_DRAIN} phase_end_t;

	typedef struct packed {
		logic              granted;
		logic [SEQ_W-1:0]  pkt_seq;
		logic              is_header;
		logic [FLEN_W-1:0] byte_offset;
		logic [PLEN_W-1:0] payload_len;
		logic [SEQ_W-1:0]  packet_count;
		logic              resend_found;
		logic [SEQ_W-1:0]  resend_seq;
		logic              window_full;
		logic              sending_done;
		logic              all_done;
	} sender_result_t;

	// Tracks the sender window and predicts the result of each item.
	class window_tracker;
		logic [FLEN_W-1:0] flen;
		logic [TMO_W-1:0]  tmo;
		logic [SEQ_W-1:0]  base;
		logic [SEQ_W-1:0]  nxt;
		bit                acked[WIN];
		logic [TIME_W-1:0] stamp[WIN];
		logic [FLEN_W-1:0] pos;
		bit                hdr_sent, hdr_acked, last_sent, last_acked;
		sender_result_t    awaited[$];
		int                errors;

		function new();
			flen = '0;
			tmo = TIMEOUT_RST;
			base = '0;
			nxt = '0;
			pos = '0;
			hdr_sent = 0;
			hdr_acked = 0;
			last_sent = 0;
			last_acked = 0;
			errors = 0;
			foreach (acked[i]) begin
				acked[i] = 0;
				stamp[i] = '0;
			end
		endfunction

		function logic [SEQ_W-1:0] in_flight();
			return nxt - base;
		endfunction

		function bit full();
			return in_flight() >= WIN;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			if (idx == CFG_FILE_LENGTH)
				flen = data[FLEN_W-1:0];
			else
				tmo = data[TMO_W-1:0];
		endfunction

		// Returns 1 when the item did real work (grant, taken ack, scan of a
		// non-empty window).
		function bit note_request(logic [1:0] req, logic [SEQ_W-1:0] ack,
				logic [TIME_W-1:0] now);
			sender_result_t    r;
			logic [SEQ_W-1:0]  d;
			logic [SEQ_W-1:0]  seq;
			logic [FLEN_W-1:0] rem;
			logic [TIME_W-1:0] age;
			logic [31:0]       cnt;
			bit                worked;
			int                k;
			r = '0;
			worked = 0;
			case (req)
				REQ_ISSUE: begin
					if (!(full() || (hdr_sent && !hdr_acked) || last_sent)) begin
						worked = 1;
						r.granted = 1;
						r.pkt_seq = nxt;
						if (!hdr_sent) begin
							cnt = ({8'd0, flen} + PB - 1) / PB;
							if (cnt > SEQ_MAX)
								cnt = SEQ_MAX;
							r.is_header = 1;
							r.packet_count = cnt[SEQ_W-1:0];
							hdr_sent = 1;
						end else begin
							// lowering the file length below the position ends the run
							rem = (flen > pos) ? flen - pos : '0;
							r.byte_offset = pos;
							if (rem <= PB) begin
								r.payload_len = rem[PLEN_W-1:0];
								pos = flen;
								last_sent = 1;
							end else begin
								r.payload_len = PLEN_W'(PB);
								pos = pos + FLEN_W'(PB);
							end
						end
						acked[nxt % WIN] = 0;
						stamp[nxt % WIN] = now;
						nxt = nxt + 1'b1;
					end
				end
				REQ_ACK: begin
					d = ack - base;
					if (d < in_flight() && !acked[ack % WIN]) begin
						worked = 1;
						if (ack == 0)
							hdr_acked = 1;
						else if (64'(ack) * PB >= 64'(flen))
							last_acked = 1;
						for (k = 0; k <= d; k++) begin
							acked[base % WIN] = 1;
							base = base + 1'b1;
						end
					end
				end
				REQ_SCAN: begin
					worked = in_flight() != 0;
					for (k = 0; k < in_flight(); k++) begin
						seq = base + SEQ_W'(k);
						age = now - stamp[seq % WIN];
						if (!acked[seq % WIN] && age > tmo) begin
							stamp[seq % WIN] = now;
							r.resend_found = 1;
							r.resend_seq = seq;
							break;
						end
					end
				end
				default: ;
			endcase
			r.window_full = full();
			r.sending_done = last_sent;
			r.all_done = last_acked;
			awaited.push_back(r);
			return worked;
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				errors++;
				$display("%0t %s: expected %0h, actual %0h", $time, name, want, seen);
			end
		endfunction

		function void check_result(sender_result_t got);
			sender_result_t exp;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t result with no item pending: expected none, actual %h",
					$time, got);
				return;
			end
			exp = awaited.pop_front();
			compare("granted", exp.granted, got.granted);
			compare("pkt_seq", exp.pkt_seq, got.pkt_seq);
			compare("is_header", exp.is_header, got.is_header);
			compare("byte_offset", exp.byte_offset, got.byte_offset);
			compare("payload_len", exp.payload_len, got.payload_len);
			compare("packet_count", exp.packet_count, got.packet_count);
			compare("resend_found", exp.resend_found, got.resend_found);
			compare("resend_seq", exp.resend_seq, got.resend_seq);
			compare("window_full", exp.window_full, got.window_full);
			compare("sending_done", exp.sending_done, got.sending_done);
			compare("all_done", exp.all_done, got.all_done);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           req_type;
	logic [SEQ_W-1:0]     ack_seq;
	logic [TIME_W-1:0]    cur_time;
	logic                 done;
	logic                 granted;
	logic [SEQ_W-1:0]     pkt_seq;
	logic                 is_header;
	logic [FLEN_W-1:0]    byte_offset;
	logic [PLEN_W-1:0]    payload_len;
	logic [SEQ_W-1:0]     packet_count;
	logic                 resend_found;
	logic [SEQ_W-1:0]     resend_seq;
	logic                 window_full;
	logic                 sending_done;
	logic                 all_done;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	window_tracker     track;
	logic [TIME_W-1:0] ms_clock;
	int                burst_left;
	int                idle_cycles = 0;

	sliding_window_sender_control #(
		.WINDOW_DEPTH (WIN),
		.PAYLOAD_BYTES(PB)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.ack_seq     (ack_seq),
		.cur_time    (cur_time),
		.done        (done),
		.granted     (granted),
		.pkt_seq     (pkt_seq),
		.is_header   (is_header),
		.byte_offset (byte_offset),
		.payload_len (payload_len),
		.packet_count(packet_count),
		.resend_found(resend_found),
		.resend_seq  (resend_seq),
		.window_full (window_full),
		.sending_done(sending_done),
		.all_done    (all_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			track.check_result('{granted: granted, pkt_seq: pkt_seq, is_header: is_header,
				byte_offset: byte_offset, payload_len: payload_len,
				packet_count: packet_count, resend_found: resend_found,
				resend_seq: resend_seq, window_full: window_full,
				sending_done: sending_done, all_done: all_done});
		end
	end

	// watchdog: cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic wait_settled();
		start <= 1'b0;
		do @(posedge clk); while (track.awaited.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic program_regs(input logic [FLEN_W-1:0] flen, input logic [TMO_W-1:0] tmo);
		wait_settled();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_FILE_LENGTH;
		cfg_data <= CFG_DAT_W'(flen);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		track.configure(CFG_FILE_LENGTH, CFG_DAT_W'(flen));
		cfg_index <= CFG_TIMEOUT_MS;
		cfg_data <= CFG_DAT_W'(tmo);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		track.configure(CFG_TIMEOUT_MS, CFG_DAT_W'(tmo));
		cfg_valid <= 1'b0;
	endtask

	// Leaves start high after the accept; the next call either keeps it up
	// with a new item or drops it for a gap.
	task automatic send_request(input logic [1:0] req, input logic [SEQ_W-1:0] ack,
			input logic [TIME_W-1:0] now, input bit hold, output bit worked);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 10);
			if ($urandom_range(0, 29) == 0)
				burst_left = $urandom_range(10, 40);
		end
		if (gap > 0 || hold) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			if (hold)
				do @(posedge clk); while (track.awaited.size() != 0);
		end
		start <= 1'b1;
		req_type <= req;
		ack_seq <= ack;
		cur_time <= now;
		do @(posedge clk); while (busy !== 1'b0);
		worked = track.note_request(req, ack, now);
	endtask

	task automatic poke(input logic [1:0] req, input logic [SEQ_W-1:0] ack,
			input logic [TIME_W-1:0] now);
		bit worked;
		send_request(req, ack, now, 1'b0, worked);
	endtask

	task automatic random_request(output logic [1:0] req, output logic [SEQ_W-1:0] ack,
			output logic [TIME_W-1:0] now);
		int pick;
		int outst;
		pick = $urandom_range(0, 99);
		outst = int'(track.in_flight());
		ms_clock = ms_clock + $urandom_range(0, int'(track.tmo) / 3 + 1);
		now = ($urandom_range(0, 15) == 0) ? TIME_W'($urandom) : ms_clock;
		ack = SEQ_W'($urandom_range(0, 32767));
		if (pick < 42) begin
			req = REQ_ISSUE;
		end else if (pick < 75) begin
			req = REQ_ACK;
			if (outst > 0)
				ack = track.base + SEQ_W'($urandom_range(0, outst - 1));
		end else if (pick < 93) begin
			req = REQ_SCAN;
		end else if (pick < 96) begin
			req = REQ_UNUSED;
		end else begin
			req = REQ_ACK;   // stray ack, mostly outside the window
		end
	endtask

	task automatic run_phase(input phase_end_t mode, input int target, input int cap);
		logic [1:0]        req;
		logic [SEQ_W-1:0]  ack;
		logic [TIME_W-1:0] now;
		bit                worked;
		int                useful;
		int                tries;
		useful = 0;
		tries = 0;
		while (tries < cap) begin
			if (mode == RUN_COUNT && useful >= target)
				break;
			if (mode == RUN_TO_LAST && track.last_sent)
				break;
			if (mode == RUN_TO_DRAIN && track.in_flight() == 0)
				break;
			random_request(req, ack, now);
			send_request(req, ack, now, $urandom_range(0, 59) == 0, worked);
			useful += worked;
			tries++;
		end
	endtask

	initial begin
		logic [FLEN_W-1:0] flen;
		track = new();
		ms_clock = 32'hFFF0_0000;
		burst_left = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_ISSUE;
		ack_seq <= '0;
		cur_time <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_FILE_LENGTH;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: header handshake, full window, wrap of time
		program_regs(24'hFF_FFFF, 16'd1);
		poke(REQ_UNUSED, 15'h7FFF, 32'hFFFF_FFFF);
		poke(REQ_SCAN, 15'd0, 32'd0);
		poke(REQ_ACK, 15'd0, 32'd0);
		poke(REQ_ISSUE, 15'd0, 32'd100);
		poke(REQ_ISSUE, 15'd0, 32'd100);       // refused, header not acked
		poke(REQ_SCAN, 15'd0, 32'd101);        // age equals the timeout
		poke(REQ_SCAN, 15'd0, 32'd102);
		poke(REQ_ACK, 15'd5, 32'd0);
		poke(REQ_ACK, 15'd0, 32'd0);
		for (int i = 0; i < WIN; i++)
			poke(REQ_ISSUE, 15'd0, 32'd200 + i);
		poke(REQ_ISSUE, 15'd0, 32'd300);       // refused, window full
		poke(REQ_ACK, 15'h7FFF, 32'd0);
		poke(REQ_ACK, 15'd3, 32'd0);
		poke(REQ_SCAN, 15'd0, 32'hFFFF_FFFF);
		poke(REQ_SCAN, 15'd0, 32'd0);
		poke(REQ_ACK, 15'd8, 32'd0);

		program_regs(24'hFF_FFFF, TMO_W'($urandom_range(2, 5000)));
		run_phase(RUN_COUNT, 480, 3000);
		program_regs(24'hFF_FFFF, 16'hFFFF);
		run_phase(RUN_COUNT, 450, 3000);

		// finish the file: either a short tail or a length pulled to or below the position
		case ($urandom_range(0, 2))
			0: flen = '0;
			1: flen = track.pos - FLEN_W'($urandom_range(0, int'(track.pos)));
			default: flen = track.pos + FLEN_W'($urandom_range(1, 1500));
		endcase
		program_regs(flen, TMO_W'($urandom_range(1, 65535)));
		run_phase(RUN_TO_LAST, 0, 500);
		program_regs(24'd0, 16'd1);
		run_phase(RUN_TO_DRAIN, 0, 800);

		start <= 1'b0;
		do @(posedge clk); while (track.awaited.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (track.errors == 0 && track.awaited.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
